FILE: design/rdc_pkg.sv
// rdc_pkg: shared constants, register codes and types of the radix digit converter
// depends on nothing; every other design file imports it
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

    // field widths of the channels
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;

    // number range and table size
    localparam int VALUE_BITS  = 32;
    localparam int MAX_RADIX   = 16;
    localparam int TABLE_CHARS = 16;
    localparam int DIGIT_W     = $clog2(TABLE_CHARS);
    localparam int RADIX_W     = 5;

    // digit buffer and digit counter
    localparam int BUF_AW = $clog2(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);

    // divider: one nibble of the dividend per step (VALUE_BITS is a multiple of 4)
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STEPS     = VALUE_BITS / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // apb port
    localparam int APB_DW = 64;
    localparam int APB_AW = 5;

    // characters that a digit table must not hold
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;

    // register indexes, address bits [4:3]
    typedef enum logic [1:0] {
        REG_CHARS_LOW  = 2'd0,
        REG_CHARS_HIGH = 2'd1,
        REG_RADIX_LEN  = 2'd2
    } t_reg_idx;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [TABLE_CHARS-1:0][CHAR_W-1:0] chars;
        logic [RADIX_W-1:0]                 radix_len;
    } t_cfg;

    // table check status
    typedef struct packed {
        logic done;
        logic ok;
    } t_chk_stat;

    // divider status and results
    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [VALUE_BITS-1:0] quot;
        logic [DIGIT_W-1:0]    rem;
    } t_div_stat;

endpackage

`default_nettype wire

FILE: design/rdc_chan_if.sv
// rdc_chan_if: valid/ready channels for input values and output digits
// depends on rdc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rdc_in_if import rdc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
    logic              bad_table;

    modport source (output valid, output digit_char, output last_digit, output bad_table,
                     input ready);
    modport sink   (input valid, input digit_char, input last_digit, input bad_table,
                    output ready);
endinterface

`default_nettype wire

FILE: design/rdc_cfg_regs.sv
// rdc_cfg_regs: apb register file holding the digit table and the radix
// depends on rdc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rdc_cfg_regs import rdc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [APB_DW-1:0]  r_chars_low;
    logic [APB_DW-1:0]  r_chars_high;
    logic [RADIX_W-1:0] r_radix_len;
    logic               wr_en;
    t_reg_idx           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[4:3]);

    // register writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars_low  <= '0;
            r_chars_high <= '0;
            r_radix_len  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CHARS_LOW:  r_chars_low  <= pwdata;
                REG_CHARS_HIGH: r_chars_high <= pwdata;
                REG_RADIX_LEN:  r_radix_len  <= pwdata[RADIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_CHARS_LOW:  prdata = r_chars_low;
            REG_CHARS_HIGH: prdata = r_chars_high;
            REG_RADIX_LEN:  prdata = {{(APB_DW-RADIX_W){1'b0}}, r_radix_len};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.chars     = {r_chars_high, r_chars_low};
    assign o_cfg.radix_len = r_radix_len;

endmodule

`default_nettype wire

FILE: design/rdc_table_check.sv
// rdc_table_check: walks the digit table one character a cycle looking for
// forbidden or repeated characters; depends on rdc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rdc_table_check import rdc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  t_cfg      i_cfg,
    output t_chk_stat o_stat
);

    logic               r_busy;
    logic               r_done;
    logic               r_ok;
    logic [DIGIT_W-1:0] r_idx;
    logic [CHAR_W-1:0]  cur_char;
    logic               len_ok;
    logic               forbidden;
    logic               dup;
    logic               at_end;
    logic [RADIX_W-1:0] len;

    assign len       = i_cfg.radix_len;
    assign len_ok    = (len >= RADIX_W'(2)) && (len <= RADIX_W'(MAX_RADIX));
    assign cur_char  = i_cfg.chars[r_idx];
    assign forbidden = (cur_char == CHAR_MINUS) || (cur_char == CHAR_PLUS)
                    || (cur_char == CHAR_DOT);
    assign at_end    = ({1'b0, r_idx} == RADIX_W'(len - RADIX_W'(1)));

    // compare the current character against every later one in use
    always_comb begin
        dup = 1'b0;
        for (int j = 0; j < TABLE_CHARS; j++) begin
            if ((RADIX_W'(j) > {1'b0, r_idx}) && (RADIX_W'(j) < len)
                && (i_cfg.chars[j] == cur_char)) begin
                dup = 1'b1;
            end
        end
    end

    // scan sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ok   <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= len_ok;
            r_done <= !len_ok;
            r_ok   <= 1'b0;
            r_idx  <= '0;
        end else if (r_busy) begin
            if (forbidden || dup) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_ok   <= 1'b0;
            end else if (at_end) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_ok   <= 1'b1;
            end else begin
                r_idx  <= r_idx + DIGIT_W'(1);
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ok   = r_ok;

endmodule

`default_nettype wire

FILE: design/rdc_divider.sv
// rdc_divider: shared long divider by the radix, one nibble of the dividend a cycle
// depends on rdc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rdc_divider import rdc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_dividend,
    input  wire logic [RADIX_W-1:0]    i_radix,
    output t_div_stat                  o_stat
);

    logic                     r_busy;
    logic                     r_done;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic [VALUE_BITS-1:0]    r_quot;
    logic [DIGIT_W-1:0]       r_rem;
    logic [DIV_STEP_BITS-1:0] nib;
    logic [DIV_STEP_BITS-1:0] q_nib;
    logic [DIGIT_W-1:0]       rem_next;

    assign nib = r_quot[VALUE_BITS-1 -: DIV_STEP_BITS];

    // four restoring steps on the top nibble; the remainder stays below the radix
    always_comb begin
        logic [RADIX_W-1:0] part;
        logic [DIGIT_W-1:0] rem;
        rem   = r_rem;
        q_nib = '0;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            part = {rem, nib[DIV_STEP_BITS-1-k]};
            if (part >= i_radix) begin
                rem = DIGIT_W'(part - i_radix);
                q_nib[DIV_STEP_BITS-1-k] = 1'b1;
            end else begin
                rem = DIGIT_W'(part);
            end
        end
        rem_next = rem;
    end

    // quotient bits shift in from the right as dividend nibbles leave on the left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[VALUE_BITS-DIV_STEP_BITS-1:0], q_nib};
            r_rem  <= rem_next;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.quot = r_quot;
    assign o_stat.rem  = r_rem;

endmodule

`default_nettype wire

FILE: design/rdc_digit_buf.sv
// rdc_digit_buf: digit index memory, one write and one registered read a cycle
// depends on rdc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rdc_digit_buf import rdc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_wr_en,
    input  wire logic [BUF_AW-1:0]  i_wr_addr,
    input  wire logic [DIGIT_W-1:0] i_wr_data,
    input  wire logic [BUF_AW-1:0]  i_rd_addr,
    output logic      [DIGIT_W-1:0] o_rd_data
);

    logic [DIGIT_W-1:0] r_mem [VALUE_BITS];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/radix_digit_converter_top.sv
// radix_digit_converter_top: sequencer, output register and apb port of the converter
// depends on rdc_pkg, rdc_chan_if, rdc_cfg_regs, rdc_table_check, rdc_divider, rdc_digit_buf
`timescale 1ns / 1ps
`default_nettype none

// Converts one 32-bit unsigned value per input beat into its digits, most
// significant first, one output beat per digit, in the radix given by
// radix_length and the digit table. A table shorter than two characters,
// longer than sixteen, holding '-', '+' or '.', or repeating a character
// gives a single beat with bad_table and last_digit set and digit_char zero.
// One value is worked at a time and i_in.ready is low until its digits have
// been produced. Per value: the value is accepted; the table is scanned, and
// a rejected length skips the scan; each digit is then worked out by the
// shared divider in eight nibble steps and written to the digit buffer; and
// the digits are sent through the digit buffer read port, last written first.
// The output register lets the next value be taken while the last digit waits.
module radix_digit_converter_top import rdc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    rdc_in_if.sink                 i_in,
    rdc_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_RD    = 6'b001000,
        S_OUT   = 6'b010000,
        S_BAD   = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [BUF_AW-1:0]     r_rd_idx, n_rd_idx;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_digit_char, n_digit_char;
    logic                  r_last_digit, n_last_digit;
    logic                  r_bad_table, n_bad_table;

    t_cfg                  cfg;
    t_chk_stat             chk_stat;
    t_div_stat             div_stat;
    logic                  chk_start;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic                  buf_we;
    logic [DIGIT_W-1:0]    rd_data;
    logic                  out_free;
    logic [CNT_W-1:0]      count_inc;

    rdc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rdc_table_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (chk_start),
        .i_cfg   (cfg),
        .o_stat  (chk_stat)
    );

    rdc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_radix    (cfg.radix_len),
        .o_stat     (div_stat)
    );

    rdc_digit_buf u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (buf_we),
        .i_wr_addr (r_count[BUF_AW-1:0]),
        .i_wr_data (div_stat.rem),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign count_inc  = r_count + CNT_W'(1);

    // sequencer: check table, divide repeatedly, send digits in reverse, or send an error beat
    always_comb begin
        n_state      = r_state;
        n_value      = r_value;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_digit_char = r_digit_char;
        n_last_digit = r_last_digit;
        n_bad_table  = r_bad_table;
        chk_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = div_stat.quot;
        buf_we       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_value   = VALUE_BITS'(i_in.value);
                    chk_start = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (chk_stat.done) begin
                    if (chk_stat.ok) begin
                        div_start    = 1'b1;
                        div_dividend = r_value;
                        n_count      = '0;
                        n_state      = S_DIV;
                    end else begin
                        n_state = S_BAD;
                    end
                end
            end
            S_BAD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_digit_char = '0;
                    n_last_digit = 1'b1;
                    n_bad_table  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    buf_we  = 1'b1;
                    n_count = count_inc;
                    if ((div_stat.quot != '0) && (count_inc < CNT_W'(VALUE_BITS))) begin
                        div_start = 1'b1;
                    end else begin
                        n_rd_idx = r_count[BUF_AW-1:0];
                        n_state  = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_digit_char = cfg.chars[rd_data];
                    n_last_digit = (r_rd_idx == '0);
                    n_bad_table  = 1'b0;
                    if (r_rd_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx - BUF_AW'(1);
                        n_state  = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_value      <= n_value;
        r_rd_idx     <= n_rd_idx;
        r_digit_char <= n_digit_char;
        r_last_digit <= n_last_digit;
        r_bad_table  <= n_bad_table;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.digit_char = r_digit_char;
    assign o_out.last_digit = r_last_digit;
    assign o_out.bad_table  = r_bad_table;

`ifndef ASSERT_OFF
    // the shared divider is never restarted in the middle of a division
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a finished division leaves a remainder below the radix
    a_div_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> ({1'b0, div_stat.rem} < cfg.radix_len))
        else $error("divider remainder not below radix");

    // an accepted table always has a usable radix
    a_chk_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chk_stat.done && chk_stat.ok) |->
            ((cfg.radix_len >= RADIX_W'(2)) && (cfg.radix_len <= RADIX_W'(MAX_RADIX))))
        else $error("table accepted with bad radix");

    // digits are only read back from buffer entries written for this value
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (CNT_W'(r_rd_idx) < r_count))
        else $error("digit read past written entries");

    // an error beat is always the single final beat with no character
    a_bad_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.bad_table) |-> (o_out.last_digit && (o_out.digit_char == '0)))
        else $error("malformed error beat");
`endif

endmodule

`default_nettype wire

FILE: verif/radix_digit_converter_top_tb.sv
// radix_digit_converter_top_tb: self-checking bench for the radix digit converter
// depends on rdc_pkg, rdc_chan_if and radix_digit_converter_top
`timescale 1ns / 1ps

module radix_digit_converter_top_tb;
    import rdc_pkg::*;

    // run limits and pacing
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          SETTLE      = 20;
    localparam int          HOLDOFF     = 400;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } t_digit_beat;

    logic i_clk;
    logic i_rst_n;

    // apb port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    wire  [APB_DW-1:0] prdata;
    wire               pready;

    rdc_in_if  in_if ();
    rdc_out_if out_if ();

    radix_digit_converter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the configuration
    logic [TABLE_CHARS-1:0][CHAR_W-1:0] digit_table;
    logic [RADIX_W-1:0]                 radix_q;

    logic [VALUE_W-1:0] values_pending[$];
    t_digit_beat        digits_due[$];
    int                 mismatches;
    int                 burst_left;
    int                 gap_left;
    int                 holdoff_left;
    bit                 holdoff_request;
    int                 stall_mode;
    logic [7:0]         stall_phase;

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table check: length in range, no sign or dot, no repeated character
    function automatic bit table_accepts();
        int n;
        n = radix_q;
        if (n < 2 || n > MAX_RADIX) return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (digit_table[i] == CHAR_MINUS || digit_table[i] == CHAR_PLUS ||
                digit_table[i] == CHAR_DOT) return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (digit_table[j] == digit_table[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected digit beats of one value, most significant first, or the error beat of a bad table
    function automatic void convert_value(input logic [VALUE_W-1:0] v);
        logic [DIGIT_W-1:0] idx[VALUE_BITS];
        logic [VALUE_W-1:0] q;
        int                 cnt;
        t_digit_beat        b;
        if (!table_accepts()) begin
            b = '{ch: '0, last: 1'b1, bad: 1'b1};
            digits_due.push_back(b);
            return;
        end
        q   = v;
        cnt = 0;
        do begin
            idx[cnt] = DIGIT_W'(q % radix_q);
            cnt++;
            q = q / radix_q;
        end while (q != 0 && cnt < VALUE_BITS);
        for (int k = 0; k < cnt; k++) begin
            b.ch   = digit_table[idx[cnt - 1 - k]];
            b.last = (k == cnt - 1);
            b.bad  = 1'b0;
            digits_due.push_back(b);
        end
    endfunction

    function automatic void check_field(input string name, input logic [CHAR_W-1:0] want,
                                        input logic [CHAR_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // input driver: bursts of values with random gaps between bursts
    always @(posedge i_clk) begin : value_driver
        logic offer;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                convert_value(in_if.value);
                void'(values_pending.pop_front());
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            offer = in_if.valid && !in_if.ready;
            if (!offer) begin
                if (gap_left > 0) gap_left--;
                else offer = (values_pending.size() != 0);
            end
            in_if.valid <= offer;
            if (offer) in_if.value <= values_pending[0];
        end
    end

    // output monitor: checks each digit beat and paces ready
    always @(posedge i_clk) begin : digit_monitor
        t_digit_beat want;
        logic        take;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (digits_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat, expected none, %s %0h last %0b bad %0b",
                             $time, "actual char", out_if.digit_char, out_if.last_digit,
                             out_if.bad_table);
                end else begin
                    want = digits_due.pop_front();
                    check_field("digit_char", want.ch, out_if.digit_char);
                    check_field("last_digit", CHAR_W'(want.last), CHAR_W'(out_if.last_digit));
                    check_field("bad_table", CHAR_W'(want.bad), CHAR_W'(out_if.bad_table));
                end
            end
            // stall pattern, with one long hold-off on request
            if (holdoff_request) begin
                holdoff_left    = HOLDOFF;
                holdoff_request = 1'b0;
            end
            stall_phase++;
            if (stall_phase == 0) stall_mode = $urandom_range(0, 2);
            if (holdoff_left > 0) begin
                holdoff_left--;
                take = 1'b0;
            end else begin
                case (stall_mode)
                    0: take = 1'b1;
                    1: take = ($urandom_range(0, 2) != 0);
                    default: take = (stall_phase[1:0] == 2'd0);
                endcase
            end
            out_if.ready <= take;
        end
    end

    // one apb write, setup then access
    task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CHARS_LOW:  digit_table[7:0]  = data;
            REG_CHARS_HIGH: digit_table[15:8] = data;
            REG_RADIX_LEN:  radix_q           = data[RADIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_table(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] len_word);
        apb_write(REG_CHARS_LOW, lo);
        apb_write(REG_CHARS_HIGH, hi);
        apb_write(REG_RADIX_LEN, len_word);
        @(negedge i_clk);
    endtask

    // random table, optionally broken in one of several ways
    task automatic random_table(input bit well_formed);
        logic [TABLE_CHARS-1:0][CHAR_W-1:0] tab;
        bit                                 used[256];
        int                                 len;
        int                                 i;
        int                                 j;
        logic [CHAR_W-1:0]                  c;
        logic [63:0]                        len_word;
        tab = {$urandom, $urandom, $urandom, $urandom};
        len = $urandom_range(2, MAX_RADIX);
        for (int k = 0; k < len; k++) begin
            do c = CHAR_W'($urandom_range(0, 255));
            while (used[c] || c == CHAR_MINUS || c == CHAR_PLUS || c == CHAR_DOT);
            used[c] = 1'b1;
            tab[k]  = c;
        end
        if (!well_formed) begin
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 1);
                1: begin
                    case ($urandom_range(0, 2))
                        0: c = CHAR_MINUS;
                        1: c = CHAR_PLUS;
                        default: c = CHAR_DOT;
                    endcase
                    tab[$urandom_range(0, len - 1)] = c;
                end
                2: begin
                    i = $urandom_range(0, len - 2);
                    j = $urandom_range(i + 1, len - 1);
                    tab[j] = tab[i];
                end
                default: len = $urandom_range(MAX_RADIX + 1, 31);
            endcase
        end
        len_word      = {$urandom, $urandom};
        len_word[4:0] = RADIX_W'(len);
        load_table(tab[7:0], tab[15:8], len_word);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return 32'hFFFF_FFFF >> $urandom_range(0, 31);
            default: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
        endcase
    endfunction

    // wait until every value is taken and every digit has come back
    task automatic wait_idle();
        @(negedge i_clk);
        while (values_pending.size() != 0 || in_if.valid || digits_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // cycle limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // stimulus sequence
    initial begin : stimulus
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_if.valid     = 1'b0;
        in_if.value     = '0;
        out_if.ready    = 1'b0;
        digit_table     = '0;
        radix_q         = '0;
        mismatches      = 0;
        burst_left      = 4;
        gap_left        = 0;
        holdoff_left    = 0;
        holdoff_request = 1'b0;
        stall_mode      = 0;
        stall_phase     = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // table left at reset: empty, so rejected
        values_pending.push_back(32'd5);
        wait_idle();

        // decimal, plus a write to an unmapped index
        apb_write(REG_UNUSED, {$urandom, $urandom});
        load_table(64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938, 64'd10);
        values_pending.push_back(32'd0);
        values_pending.push_back(32'd1);
        values_pending.push_back(32'd9);
        values_pending.push_back(32'd10);
        values_pending.push_back(32'hFFFF_FFFF);
        values_pending.push_back(32'h8000_0000);
        values_pending.push_back(32'd1_000_000_000);
        wait_idle();

        // binary, junk in the upper length bits, sign and dot past the length
        load_table(64'h2D2B_2E41_4243_3130, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFE2);
        values_pending.push_back(32'hFFFF_FFFF);
        values_pending.push_back(32'd0);
        values_pending.push_back(32'h5555_5555);
        wait_idle();

        // sixteen characters with a zero byte in use
        load_table(64'h3736_3534_3332_3130, 64'h0065_6463_6261_3938, 64'd16);
        values_pending.push_back(32'hFFFF_FFFF);
        values_pending.push_back(32'h1234_5678);
        values_pending.push_back(32'd15);
        wait_idle();

        // rejected tables: too short, too long, sign, plus, dot, repeat
        load_table(64'h3736_3534_3332_3130, 64'h0065_6463_6261_3938, 64'd1);
        values_pending.push_back(32'd7);
        wait_idle();
        load_table(64'h3736_3534_3332_3130, 64'h0065_6463_6261_3938, 64'd17);
        values_pending.push_back(32'd77);
        wait_idle();
        load_table(64'h3736_3534_3332_3130, 64'h0065_6463_6261_3938, 64'd31);
        values_pending.push_back(32'hFFFF_FFFF);
        wait_idle();
        load_table(64'h3736_3534_2D32_3130, 64'h0000_0000_0000_3938, 64'd10);
        values_pending.push_back(32'd123);
        wait_idle();
        load_table(64'h3736_3534_3332_3130, 64'h0065_6463_6261_2B38, 64'd16);
        values_pending.push_back(32'd456);
        wait_idle();
        load_table(64'h3736_3534_3332_312E, 64'h0000_0000_0000_3938, 64'd10);
        values_pending.push_back(32'd0);
        wait_idle();
        load_table(64'h3736_3534_3332_3130, 64'h0000_0000_0000_3038, 64'd10);
        values_pending.push_back(32'd42);
        wait_idle();

        // random tables and values; the first phase also holds the output off
        for (int p = 0; p < 12; p++) begin
            random_table(p == 0 || $urandom_range(0, 4) != 0);
            for (int n = 0; n < 29; n++) values_pending.push_back(random_value());
            if (p == 0) holdoff_request = 1'b1;
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
design/rdc_pkg.sv
design/rdc_chan_if.sv
design/rdc_cfg_regs.sv
design/rdc_table_check.sv
design/rdc_divider.sv
design/rdc_digit_buf.sv
design/radix_digit_converter_top.sv
verif/radix_digit_converter_top_tb.sv
